>>> hdl/tnlp_pkg.sv
// ----------------------------------------------------------------------------
// tnlp_pkg: shared definitions for the timestamp/name line parser
// Widths, limits, codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tnlp_pkg;

    // Limits
    localparam int NAME_LIMIT   = 48;   // name must be shorter than this
    localparam int LINE_LIMIT   = 128;  // line must be shorter than this
    localparam int STAMP_DIGITS = 19;   // max timestamp digits

    localparam int BYTE_W   = 8;
    localparam int STAMP_W  = 64;
    localparam int STATUS_W = 2;
    localparam int LINE_W   = 8;                     // saturating line length
    localparam int DIGIT_W  = 5;
    localparam int NAME_W   = $clog2(NAME_LIMIT);    // name length / store index
    localparam int NAME_DEPTH = NAME_LIMIT - 1;
    localparam int TDATA_W  = BYTE_W + STAMP_W;      // 72, already whole bytes

    // Line status codes
    localparam logic [STATUS_W-1:0] ST_GOOD   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STAMP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NAME   = 2'd3;

    // Character source for one parse step
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_HELD,
        SRC_CR
    } char_src_t;

    // Controller -> datapath
    typedef struct packed {
        logic      capture;      // latch incoming byte
        logic      take;         // run one parse step
        char_src_t src;
        logic      set_pending;
        logic      clr_pending;
        logic      set_ended;
        logic      rd_en;        // read name store at replay pointer
        logic      load_name;    // output register <- name byte
        logic      load_final;   // output register <- final word, clear line
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic byte_zero;
        logic byte_nl;
        logic byte_cr;
        logic pending;
        logic ended;
        logic line_good;
        logic rd_last;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/tnlp_ctrl.sv
// ----------------------------------------------------------------------------
// tnlp_ctrl: sequencer for the line parser
// Accepts bytes, orders CR replay steps and the name replay at each newline.
// ----------------------------------------------------------------------------
module tnlp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  tnlp_pkg::stat_t stat,
    output tnlp_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HOLD  = 3'd1;  // parse byte held behind a CR
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.src = tnlp_pkg::SRC_INPUT;
        cmd.capture = accept;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !stat.ended) begin
                    priority if (stat.byte_zero) begin
                        cmd.set_ended = 1'b1;
                    end else if (stat.byte_nl) begin
                        state_next = stat.line_good ? S_READ : S_FINAL;
                    end else if (stat.pending) begin
                        // stale CR is an ordinary character
                        cmd.take = 1'b1;
                        cmd.src  = tnlp_pkg::SRC_CR;
                        if (!stat.byte_cr) begin
                            cmd.clr_pending = 1'b1;
                            state_next = S_HOLD;
                        end
                    end else if (stat.byte_cr) begin
                        cmd.set_pending = 1'b1;
                    end else begin
                        cmd.take = 1'b1;
                    end
                end
            end
            S_HOLD: begin
                cmd.take = 1'b1;
                cmd.src  = tnlp_pkg::SRC_HELD;
                state_next = S_IDLE;
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.load_name = 1'b1;
                    state_next = stat.rd_last ? S_FINAL : S_READ;
                end
            end
            S_FINAL: begin
                if (stat.out_free) begin
                    cmd.load_final = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/tnlp_datapath.sv
// ----------------------------------------------------------------------------
// tnlp_datapath: line state, name store and output register
// One parse step per take command; name replay through a registered read.
// ----------------------------------------------------------------------------
module tnlp_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tnlp_pkg::BYTE_W-1:0]    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tnlp_pkg::TDATA_W-1:0]   m_tdata,
    output logic [tnlp_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tlast,
    input  tnlp_pkg::cmd_t                 cmd,
    output tnlp_pkg::stat_t                stat
);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_NAME   = 2'd2;
    localparam logic [1:0] PH_BAD    = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [tnlp_pkg::LINE_W-1:0]  LINE_SAT   = '1;
    localparam logic [tnlp_pkg::LINE_W-1:0]  LINE_MAX   = tnlp_pkg::LINE_W'(tnlp_pkg::LINE_LIMIT);
    localparam logic [tnlp_pkg::DIGIT_W-1:0] DIGIT_MAX  =
        tnlp_pkg::DIGIT_W'(tnlp_pkg::STAMP_DIGITS);
    localparam logic [tnlp_pkg::NAME_W-1:0]  NAME_MAX   =
        tnlp_pkg::NAME_W'(tnlp_pkg::NAME_LIMIT - 1);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic name_ok(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT);
    endfunction

    // line state
    logic [1:0]                      phase_reg, phase_next;
    logic [tnlp_pkg::STAMP_W-1:0]    stamp_reg, stamp_next;
    logic [tnlp_pkg::DIGIT_W-1:0]    digits_reg, digits_next;
    logic [tnlp_pkg::LINE_W-1:0]     line_len_reg, line_len_next;
    logic [tnlp_pkg::NAME_W-1:0]     name_len_reg, name_len_next;
    logic [tnlp_pkg::STATUS_W-1:0]   bad_reg, bad_next;
    logic                            pending_reg, pending_next;
    logic                            ended_reg, ended_next;
    logic [tnlp_pkg::NAME_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [7:0]                      held_reg;

    // name store
    logic [7:0]                      name_mem [tnlp_pkg::NAME_DEPTH];
    logic [7:0]                      rd_data_reg;
    logic                            mem_wr;

    // output register
    logic                            out_valid_reg;
    logic [7:0]                      out_name_reg;
    logic [tnlp_pkg::STAMP_W-1:0]    out_stamp_reg;
    logic [tnlp_pkg::STATUS_W-1:0]   out_status_reg;
    logic                            out_last_reg;

    logic [7:0]                      ch;
    logic [tnlp_pkg::STAMP_W-1:0]    digit_ext;
    logic [tnlp_pkg::STATUS_W-1:0]   line_stat;
    logic                            out_free;

    always_comb begin
        unique case (cmd.src)
            tnlp_pkg::SRC_HELD: ch = held_reg;
            tnlp_pkg::SRC_CR:   ch = CH_CR;
            default:            ch = s_tdata;
        endcase
    end

    assign digit_ext = tnlp_pkg::STAMP_W'(ch - 8'h30);

    // verdict on the current line
    always_comb begin
        priority if ((line_len_reg == '0) || (line_len_reg >= LINE_MAX)) begin
            line_stat = tnlp_pkg::ST_LENGTH;
        end else if (phase_reg == PH_BAD) begin
            line_stat = bad_reg;
        end else if (phase_reg != PH_NAME) begin
            line_stat = tnlp_pkg::ST_STAMP;
        end else if (name_len_reg == '0) begin
            line_stat = tnlp_pkg::ST_NAME;
        end else begin
            line_stat = tnlp_pkg::ST_GOOD;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        stamp_next    = stamp_reg;
        digits_next   = digits_reg;
        line_len_next = line_len_reg;
        name_len_next = name_len_reg;
        bad_next      = bad_reg;
        pending_next  = pending_reg;
        ended_next    = ended_reg;
        rd_idx_next   = rd_idx_reg;
        mem_wr        = 1'b0;

        if (cmd.take) begin
            if (line_len_reg != LINE_SAT) begin
                line_len_next = line_len_reg + 1'b1;
            end
            unique case (phase_reg)
                PH_FIRST: begin
                    if (is_digit(ch)) begin
                        stamp_next  = digit_ext;
                        digits_next = tnlp_pkg::DIGIT_W'(1);
                        phase_next  = PH_DIGITS;
                    end else begin
                        phase_next = PH_BAD;
                        bad_next   = tnlp_pkg::ST_STAMP;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit(ch)) begin
                        if (digits_reg >= DIGIT_MAX) begin
                            phase_next = PH_BAD;
                            bad_next   = tnlp_pkg::ST_STAMP;
                        end else begin
                            // x10 as shift-and-add
                            stamp_next  = {stamp_reg[tnlp_pkg::STAMP_W-4:0], 3'b000} +
                                          {stamp_reg[tnlp_pkg::STAMP_W-2:0], 1'b0} +
                                          digit_ext;
                            digits_next = digits_reg + 1'b1;
                        end
                    end else if (ch == CH_SPACE) begin
                        name_len_next = '0;
                        phase_next    = PH_NAME;
                    end else begin
                        phase_next = PH_BAD;
                        bad_next   = tnlp_pkg::ST_STAMP;
                    end
                end
                PH_NAME: begin
                    if ((name_len_reg >= NAME_MAX) || !name_ok(ch) ||
                        ((name_len_reg == '0) && (ch == CH_DOT))) begin
                        phase_next = PH_BAD;
                        bad_next   = tnlp_pkg::ST_NAME;
                    end else begin
                        mem_wr        = 1'b1;
                        name_len_next = name_len_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.set_pending) pending_next = 1'b1;
        if (cmd.clr_pending) pending_next = 1'b0;
        if (cmd.set_ended)   ended_next   = 1'b1;
        if (cmd.load_name)   rd_idx_next  = rd_idx_reg + 1'b1;

        if (cmd.load_final) begin
            phase_next    = PH_FIRST;
            stamp_next    = '0;
            digits_next   = '0;
            line_len_next = '0;
            name_len_next = '0;
            bad_next      = tnlp_pkg::ST_GOOD;
            pending_next  = 1'b0;
            rd_idx_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            stamp_reg    <= '0;
            digits_reg   <= '0;
            line_len_reg <= '0;
            name_len_reg <= '0;
            bad_reg      <= tnlp_pkg::ST_GOOD;
            pending_reg  <= 1'b0;
            ended_reg    <= 1'b0;
            rd_idx_reg   <= '0;
        end else begin
            phase_reg    <= phase_next;
            stamp_reg    <= stamp_next;
            digits_reg   <= digits_next;
            line_len_reg <= line_len_next;
            name_len_reg <= name_len_next;
            bad_reg      <= bad_next;
            pending_reg  <= pending_next;
            ended_reg    <= ended_next;
            rd_idx_reg   <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            held_reg <= s_tdata;
        end
    end

    // name store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            name_mem[name_len_reg] <= ch;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= name_mem[rd_idx_reg];
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_name || cmd.load_final) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_name) begin
            out_name_reg   <= rd_data_reg;
            out_stamp_reg  <= '0;
            out_status_reg <= tnlp_pkg::ST_GOOD;
            out_last_reg   <= 1'b0;
        end else if (cmd.load_final) begin
            out_name_reg   <= '0;
            out_stamp_reg  <= (line_stat == tnlp_pkg::ST_GOOD) ? stamp_reg : '0;
            out_status_reg <= line_stat;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_stamp_reg, out_name_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign stat.byte_zero = (s_tdata == 8'h00);
    assign stat.byte_nl   = (s_tdata == CH_NL);
    assign stat.byte_cr   = (s_tdata == CH_CR);
    assign stat.pending   = pending_reg;
    assign stat.ended     = ended_reg;
    assign stat.line_good = (line_stat == tnlp_pkg::ST_GOOD);
    assign stat.rd_last   = ((rd_idx_reg + 1'b1) == name_len_reg);
    assign stat.out_free  = out_free;

endmodule

>>> hdl/timestamp_name_line_parser.sv
// ----------------------------------------------------------------------------
// timestamp_name_line_parser: "<timestamp> <name>" line parser
// Parses a byte stream line by line; replays the name of each good line,
// then a final word with the timestamp, or one status word for a bad line.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Word contents
//  s_       in   s_tvalid/s_tready  tdata[7:0] text_byte
//  m_       out  m_tvalid/m_tready  tdata[7:0] name_byte, tdata[71:8] stamp_ms,
//                                   tuser[1:0] line_status, tlast last
//
//  Bytes: an ordinary byte is parsed as it is taken; a non-CR byte that
//  follows a held CR is held and parsed next (the CR is parsed first as a plain
//  character). Newline: after it is taken, each name byte gets a name store
//  registered read, then an output load, and the final word follows; a bad
//  line goes straight to the final word.
//  Input is taken whenever the sequencer is idle, even with a word still
//  waiting in the output register; output stalls hold the name replay.
//  Reset is synchronous, active low; the name store needs no clearing.
//  After a zero byte all further bytes are accepted and dropped until reset.
//
module timestamp_name_line_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tnlp_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] text_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tnlp_pkg::TDATA_W-1:0]  m_tdata,   // [7:0] name_byte, [71:8] stamp_ms
    output logic [tnlp_pkg::STATUS_W-1:0] m_tuser,   // [1:0] line_status
    output logic                          m_tlast    // last word of the line
);

    tnlp_pkg::cmd_t  cmd;
    tnlp_pkg::stat_t stat;

    // sequencer: byte acceptance, CR ordering, name replay
    tnlp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // line state, name store, output register
    tnlp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> hdl/tnlp_checker.sv
// ----------------------------------------------------------------------------
// tnlp_checker: port-level checks for the line parser
// Watches the result stream for stall behavior and field consistency, and input ready during name replay.
// ----------------------------------------------------------------------------
module tnlp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tnlp_pkg::TDATA_W-1:0]  m_tdata,
    input logic [tnlp_pkg::STATUS_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // a stalled word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed under stall");

    // name words carry no stamp and good status
    a_name_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tuser == tnlp_pkg::ST_GOOD) &&
        (m_tdata[tnlp_pkg::TDATA_W-1:tnlp_pkg::BYTE_W] == '0))
        else $error("name word with stamp or status");

    // final words carry a zero name byte
    a_final_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[tnlp_pkg::BYTE_W-1:0] == '0))
        else $error("final word with name byte");

    // a bad-line status word has no timestamp
    a_bad_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != tnlp_pkg::ST_GOOD) |->
        m_tlast && (m_tdata[tnlp_pkg::TDATA_W-1:tnlp_pkg::BYTE_W] == '0))
        else $error("status word malformed");

    // input stays closed while a name word is out, the replay is not done
    a_replay_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open during name replay");

endmodule

bind timestamp_name_line_parser tnlp_checker u_tnlp_checker (.*);
